// ===== hdl/svpwm_pkg.sv =====
// Shared constants, types and the elaboration-time sine routine for the
// space-vector PWM block. No dependencies.
`default_nettype none
package svpwm_pkg;

  localparam int unsigned FULL_TURN    = 5760;
  localparam int unsigned HALF_TURN    = 2880;
  localparam int unsigned QUARTER_TURN = 1440;

  localparam int ANG_W  = 13;
  localparam int SUM_W  = 14;
  localparam int PROD_W = 20;
  localparam int RED_W  = 16;
  localparam int EL_W   = 13;
  localparam int REM_W  = 11;
  localparam int MAG_W  = 26;
  localparam int TS_W   = 16;

  // floor(2^32 / 1440)
  localparam logic [21:0] RECIP_1440 = 22'd2982616;
  localparam logic [16:0] COS30_Q16  = 17'd56756;
  localparam logic [16:0] SQRT3_Q16  = 17'd113512;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_D   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_Q   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE  = 3'd5;

  typedef logic [2:0] sector_t;
  localparam sector_t SEC_1 = 3'd1;
  localparam sector_t SEC_2 = 3'd2;
  localparam sector_t SEC_3 = 3'd3;
  localparam sector_t SEC_4 = 3'd4;
  localparam sector_t SEC_5 = 3'd5;
  localparam sector_t SEC_6 = 3'd6;

  typedef struct packed {
    sector_t          sector;
    logic [MAG_W-1:0] m1;
    logic [MAG_W-1:0] m2;
  } vec_t;

  // sin(x), x in Q30 radians, Taylor series, rounded to frac bits
  function automatic logic [63:0] sine_q30(input logic [63:0] x, input int frac);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] acc;
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) acc = acc - signed'(term);
      else acc = acc + signed'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sd1073741824) acc = 64'sd1073741824;
    v = (unsigned'(acc) + (64'd1 << (29 - frac))) >> (30 - frac);
    if (v > (64'd1 << frac)) v = 64'd1 << frac;
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/svpwm_voltage_to_duty_times.sv =====
// Space-vector PWM: one rotor angle in, three phase compare times, sector and
// overmodulation flag out. Depends on svpwm_pkg, svpwm_angle, svpwm_vec, svpwm_div.
//
// Fully pipelined: one beat is taken every clock unless the output is stalled.
// Most of the depth is in the two bit-per-stage dividers: 36 stages
// for the active times (divide by bus voltage) and 16 for the overmodulation
// rescale. A stalled output beat freezes the whole pipeline; nothing is lost.
// Configuration registers may be written only while no beat is in flight.
`default_nettype none
module svpwm_voltage_to_duty_times import svpwm_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int TRIG_WIDTH       = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ANG_W-1:0]     in_mech_angle,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_time_a,
  output logic [15:0]          out_time_b,
  output logic [15:0]          out_time_c,
  output logic [2:0]           out_sector,
  output logic                 out_overmod,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int TM_W  = TS_W + MAG_W;
  localparam int LP_W  = 38;
  localparam int X_W   = 60;
  localparam int D1_W  = 36;
  localparam int SM_W  = D1_W + 1;
  localparam int PH_W  = 34;
  localparam int D2_W  = 53;
  localparam int TAG_W = 3 + 1 + 2 * TS_W;

  logic signed [15:0] volt_d_r, volt_q_r;
  logic [15:0]        bus_r, ts_r;
  logic [5:0]         pp_r;
  logic               rev_r;
  logic [15:0]        bus_eff;
  logic               en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_d_r <= 16'sd0;
      volt_q_r <= 16'sd512;
      bus_r    <= 16'd3072;
      ts_r     <= 16'd4096;
      pp_r     <= 6'd11;
      rev_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLT_D:  volt_d_r <= signed'(cfg_data);
        REG_VOLT_Q:  volt_q_r <= signed'(cfg_data);
        REG_BUS:     bus_r    <= cfg_data;
        REG_PERIOD:  ts_r     <= cfg_data;
        REG_POLES:   pp_r     <= cfg_data[5:0];
        REG_REVERSE: rev_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign bus_eff  = (bus_r == 16'd0) ? 16'd1 : bus_r;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic             ang_v;
  logic [1:0]       ang_quad;
  logic [IDX_W-1:0] ang_idx;

  svpwm_angle #(.DEPTH(SINE_TABLE_DEPTH)) u_angle (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (in_valid),
    .mech_i (in_mech_angle),
    .rev_i  (rev_r),
    .pp_i   (pp_r),
    .v_o    (ang_v),
    .quad_o (ang_quad),
    .idx_o  (ang_idx)
  );

  logic vec_v;
  vec_t vec;

  svpwm_vec #(.DEPTH(SINE_TABLE_DEPTH), .TW(TRIG_WIDTH)) u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_i      (ang_v),
    .quad_i   (ang_quad),
    .idx_i    (ang_idx),
    .volt_d_i (volt_d_r),
    .volt_q_i (volt_q_r),
    .v_o      (vec_v),
    .vec_o    (vec)
  );

  // active times: round(sqrt3 * Ts * m / (bus * 2^8))
  logic [2:0]      tv_r;
  logic [TM_W-1:0] tm1_r, tm2_r;
  logic [LP_W-1:0] lo1_r, hi1_r, lo2_r, hi2_r;
  logic [D1_W-1:0] dn1_r, dn2_r;
  sector_t         sa_r, sb_r, sc_r;
  logic [X_W-1:0]  x1, x2;

  assign x1 = (X_W'(hi1_r) << 21) + X_W'(lo1_r) + (X_W'(bus_eff) << 23);
  assign x2 = (X_W'(hi2_r) << 21) + X_W'(lo2_r) + (X_W'(bus_eff) << 23);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= '0;
    end else if (en) begin
      tv_r <= {tv_r[1:0], vec_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tm1_r <= TM_W'(ts_r) * TM_W'(vec.m1);
      tm2_r <= TM_W'(ts_r) * TM_W'(vec.m2);
      sa_r  <= vec.sector;
      lo1_r <= LP_W'(tm1_r[20:0]) * LP_W'(SQRT3_Q16);
      hi1_r <= LP_W'(tm1_r[TM_W-1:21]) * LP_W'(SQRT3_Q16);
      lo2_r <= LP_W'(tm2_r[20:0]) * LP_W'(SQRT3_Q16);
      hi2_r <= LP_W'(tm2_r[TM_W-1:21]) * LP_W'(SQRT3_Q16);
      sb_r  <= sa_r;
      dn1_r <= x1[X_W-1:24];
      dn2_r <= x2[X_W-1:24];
      sc_r  <= sb_r;
    end
  end

  logic                     d1_v;
  logic [1:0][D1_W-1:0]     d1_q;
  sector_t                  d1_sec;

  svpwm_div #(.NW(D1_W), .DVW(16), .QW(D1_W), .LANES(2), .TAGW(3)) u_div_t (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (tv_r[2]),
    .num_i ({dn2_r, dn1_r}),
    .den_i (bus_eff),
    .tag_i (sc_r),
    .v_o   (d1_v),
    .quo_o (d1_q),
    .tag_o (d1_sec)
  );

  // overmodulation rescale: t1 = (Ts*t1 + sum/2) / sum
  logic [2:0]      rv_r;
  logic [D1_W-1:0] t1_r;
  logic [TS_W-1:0] t2a_r, t1b_r, t2b_r, t1c_r, t2c_r;
  logic [SM_W-1:0] sum_r, sumb_r, sumc_r;
  logic            ova_r, ovb_r, ovc_r;
  sector_t         ra_r, rb_r, rc_r;
  logic [PH_W-1:0] ph_r, pl_r;
  logic [D2_W-1:0] dn3_r;
  logic [SM_W-1:0] sum_nxt;

  assign sum_nxt = SM_W'(d1_q[0]) + SM_W'(d1_q[1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= '0;
    end else if (en) begin
      rv_r <= {rv_r[1:0], d1_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= d1_q[0];
      t2a_r  <= d1_q[1][TS_W-1:0];
      sum_r  <= sum_nxt;
      ova_r  <= sum_nxt > SM_W'(ts_r);
      ra_r   <= d1_sec;
      ph_r   <= PH_W'(ts_r) * PH_W'(t1_r[D1_W-1:18]);
      pl_r   <= PH_W'(ts_r) * PH_W'(t1_r[17:0]);
      t1b_r  <= t1_r[TS_W-1:0];
      t2b_r  <= t2a_r;
      sumb_r <= sum_r;
      ovb_r  <= ova_r;
      rb_r   <= ra_r;
      dn3_r  <= (D2_W'(ph_r) << 18) + D2_W'(pl_r) + D2_W'(sumb_r >> 1);
      t1c_r  <= t1b_r;
      t2c_r  <= t2b_r;
      sumc_r <= sumb_r;
      ovc_r  <= ovb_r;
      rc_r   <= rb_r;
    end
  end

  logic                  d2_v;
  logic [0:0][TS_W-1:0]  d2_q;
  logic [TAG_W-1:0]      d2_tag;

  svpwm_div #(.NW(D2_W), .DVW(SM_W), .QW(TS_W), .LANES(1), .TAGW(TAG_W)) u_div_r (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (rv_r[2]),
    .num_i (dn3_r),
    .den_i (sumc_r),
    .tag_i ({rc_r, ovc_r, t1c_r, t2c_r}),
    .v_o   (d2_v),
    .quo_o (d2_q),
    .tag_o (d2_tag)
  );

  // zero time and phase assembly
  sector_t         fsec;
  logic            fov;
  logic [TS_W-1:0] ft1, ft2, qcl, t1_nxt, t2_nxt, t7_nxt;

  assign fsec = d2_tag[TAG_W-1 -: 3];
  assign fov  = d2_tag[2*TS_W];
  assign ft1  = d2_tag[2*TS_W-1:TS_W];
  assign ft2  = d2_tag[TS_W-1:0];
  assign qcl  = (d2_q[0] > ts_r) ? ts_r : d2_q[0];

  always_comb begin
    t1_nxt = fov ? qcl : ft1;
    t2_nxt = fov ? (ts_r - qcl) : ft2;
    t7_nxt = (ts_r - t1_nxt - t2_nxt) >> 1;
  end

  logic            fv_r, out_valid_r;
  logic [TS_W-1:0] ot1_r, ot2_r, ot7_r;
  sector_t         osec_r, sec_out_r;
  logic            oov_r, ov_out_r;
  logic [TS_W-1:0] ta_r, tb_r, tc_r;
  logic [TS_W-1:0] tfull, thalf;
  logic [TS_W-1:0] ta_nxt, tb_nxt, tc_nxt;

  assign thalf = ot7_r + ot2_r;
  assign tfull = thalf + ot1_r;

  always_comb begin
    case (osec_r)
      SEC_1: begin
        ta_nxt = tfull;
        tb_nxt = thalf;
        tc_nxt = ot7_r;
      end
      SEC_2: begin
        ta_nxt = thalf;
        tb_nxt = tfull;
        tc_nxt = ot7_r;
      end
      SEC_3: begin
        ta_nxt = ot7_r;
        tb_nxt = tfull;
        tc_nxt = thalf;
      end
      SEC_4: begin
        ta_nxt = ot7_r;
        tb_nxt = thalf;
        tc_nxt = tfull;
      end
      SEC_5: begin
        ta_nxt = thalf;
        tb_nxt = ot7_r;
        tc_nxt = tfull;
      end
      default: begin
        ta_nxt = tfull;
        tb_nxt = ot7_r;
        tc_nxt = thalf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      fv_r        <= d2_v;
      out_valid_r <= fv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ot1_r     <= t1_nxt;
      ot2_r     <= t2_nxt;
      ot7_r     <= t7_nxt;
      osec_r    <= fsec;
      oov_r     <= fov;
      ta_r      <= ta_nxt;
      tb_r      <= tb_nxt;
      tc_r      <= tc_nxt;
      sec_out_r <= osec_r;
      ov_out_r  <= oov_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_time_a  = ta_r;
  assign out_time_b  = tb_r;
  assign out_time_c  = tc_r;
  assign out_sector  = sec_out_r;
  assign out_overmod = ov_out_r;

endmodule
`default_nettype wire

// ===== hdl/svpwm_angle.sv =====
// Angle front end: mechanical angle to electrical quadrant and table index.
// Depends on svpwm_pkg.
`default_nettype none
module svpwm_angle import svpwm_pkg::*; #(
  parameter int DEPTH = 1024,
  localparam int IDX_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             v_i,
  input  logic [ANG_W-1:0] mech_i,
  input  logic             rev_i,
  input  logic [5:0]       pp_i,
  output logic             v_o,
  output logic [1:0]       quad_o,
  output logic [IDX_W-1:0] idx_o
);

  localparam int NW = $clog2((QUARTER_TURN - 1) * DEPTH + QUARTER_TURN / 2 + 1);

  logic [7:0]        v_r;
  logic [SUM_W-1:0]  a_r;
  logic [PROD_W-1:0] p_r;
  logic [RED_W-1:0]  x_r;
  logic [EL_W-1:0]   e_r;
  logic [REM_W-1:0]  rm_r;
  logic [NW-1:0]     n_r;
  logic [NW-1:0]     n7_r;
  logic [IDX_W-1:0]  q0_r;
  logic [1:0]        quad5_r, quad6_r, quad7_r, quad8_r;
  logic [IDX_W-1:0]  idx_r;

  logic [PROD_W-1:0] red_a;
  logic [RED_W-1:0]  red_b;
  logic [1:0]        quad_nxt;
  logic [EL_W-1:0]   off;
  logic [NW+21:0]    rprod;
  logic [NW-1:0]     rem;
  logic [IDX_W:0]    idx_w;
  logic [IDX_W-1:0]  idx_nxt;

  always_comb begin
    red_a = p_r;
    for (int k = 6; k >= 3; k--) begin
      if (red_a >= PROD_W'(FULL_TURN << k)) red_a = red_a - PROD_W'(FULL_TURN << k);
    end
  end

  always_comb begin
    red_b = x_r;
    for (int k = 2; k >= 0; k--) begin
      if (red_b >= RED_W'(FULL_TURN << k)) red_b = red_b - RED_W'(FULL_TURN << k);
    end
  end

  always_comb begin
    if (e_r >= EL_W'(3 * QUARTER_TURN)) begin
      quad_nxt = 2'd3;
      off = EL_W'(3 * QUARTER_TURN);
    end else if (e_r >= EL_W'(HALF_TURN)) begin
      quad_nxt = 2'd2;
      off = EL_W'(HALF_TURN);
    end else if (e_r >= EL_W'(QUARTER_TURN)) begin
      quad_nxt = 2'd1;
      off = EL_W'(QUARTER_TURN);
    end else begin
      quad_nxt = 2'd0;
      off = '0;
    end
  end

  assign rprod = (NW + 22)'(n_r) * (NW + 22)'(RECIP_1440);

  always_comb begin
    rem   = n7_r - NW'(q0_r) * NW'(QUARTER_TURN);
    idx_w = (IDX_W + 1)'(q0_r) + (IDX_W + 1)'(rem >= NW'(QUARTER_TURN));
    if (idx_w > (IDX_W + 1)'(DEPTH)) idx_nxt = IDX_W'(DEPTH);
    else idx_nxt = idx_w[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= SUM_W'(mech_i) + (rev_i ? SUM_W'(HALF_TURN) : SUM_W'(0));
      p_r     <= PROD_W'(a_r) * PROD_W'(pp_i);
      x_r     <= red_a[RED_W-1:0];
      e_r     <= red_b[EL_W-1:0];
      rm_r    <= REM_W'(e_r - off);
      quad5_r <= quad_nxt;
      n_r     <= NW'(rm_r) * NW'(DEPTH) + NW'(QUARTER_TURN / 2);
      quad6_r <= quad5_r;
      q0_r    <= rprod[32 +: IDX_W];
      n7_r    <= n_r;
      quad7_r <= quad6_r;
      idx_r   <= idx_nxt;
      quad8_r <= quad7_r;
    end
  end

  assign v_o    = v_r[7];
  assign quad_o = quad8_r;
  assign idx_o  = idx_r;

endmodule
`default_nettype wire

// ===== hdl/svpwm_vec.sv =====
// Sine ROM, inverse Park, phase projections, sector and rounded magnitudes.
// Depends on svpwm_pkg.
`default_nettype none
module svpwm_vec import svpwm_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int TW    = 16,
  localparam int IDX_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  logic [1:0]         quad_i,
  input  logic [IDX_W-1:0]   idx_i,
  input  logic signed [15:0] volt_d_i,
  input  logic signed [15:0] volt_q_i,
  output logic               v_o,
  output vec_t               vec_o
);

  localparam int F   = TW - 2;
  localparam int RW  = F + 1;
  localparam int PRW = 16 + TW;
  localparam int UW  = 17 + TW;
  localparam int AW  = TW + 35;
  localparam int PW  = TW + 36;
  localparam logic [PW-1:0] RND = PW'(1) << (F + 7);

  typedef logic [RW-1:0] rom_t [0:DEPTH];

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] x;
    for (int i = 0; i <= DEPTH; i++) begin
      x    = (64'(i) * HALF_PI_Q30 + 64'(DEPTH / 2)) / 64'(DEPTH);
      t[i] = RW'(sine_q30(x, F));
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic logic [MAG_W-1:0] mag(input logic signed [PW-1:0] p);
    logic [PW-1:0] val;
    val = p[PW-1] ? (RND - unsigned'(p)) : (unsigned'(p) + RND);
    return val[F+8 +: MAG_W];
  endfunction

  logic [7:0]             v_r;
  logic [RW-1:0]          sv_r, cv_r;
  logic [1:0]             quad1_r;
  logic signed [TW-1:0]   s_r, c_r;
  logic signed [PRW-1:0]  dc_r, qs_r, ds_r, qc_r;
  logic signed [UW-1:0]   ua_r, ub_r, ub5_r;
  logic signed [AW-1:0]   a5_r;
  logic signed [PW-1:0]   p1_r, p2_r, p3_r;
  logic signed [PW-1:0]   p1s_r, p2s_r, p3s_r;
  sector_t                sec_r;
  vec_t                   vec_r;

  logic signed [TW-1:0]   sp, cp, s_nxt, c_nxt;
  logic signed [PW-1:0]   bterm, p1_nxt, p2_nxt, p3_nxt;
  sector_t                sec_nxt;
  logic signed [PW-1:0]   sel1, sel2;

  assign sp = $signed({1'b0, sv_r});
  assign cp = $signed({1'b0, cv_r});

  always_comb begin
    case (quad1_r)
      2'd0: begin
        s_nxt = sp;
        c_nxt = cp;
      end
      2'd1: begin
        s_nxt = cp;
        c_nxt = -sp;
      end
      2'd2: begin
        s_nxt = -sp;
        c_nxt = -cp;
      end
      default: begin
        s_nxt = -cp;
        c_nxt = sp;
      end
    endcase
  end

  always_comb begin
    bterm  = PW'(ub5_r) <<< 15;
    p1_nxt = PW'(ub5_r) <<< 16;
    p2_nxt = -PW'(a5_r) - bterm;
    p3_nxt = PW'(a5_r) - bterm;
  end

  always_comb begin
    case ({p1_r > 0, p2_r > 0, p3_r > 0})
      3'b101:  sec_nxt = SEC_1;
      3'b100:  sec_nxt = SEC_2;
      3'b110:  sec_nxt = SEC_3;
      3'b010:  sec_nxt = SEC_4;
      3'b011:  sec_nxt = SEC_5;
      default: sec_nxt = SEC_6;
    endcase
  end

  always_comb begin
    case (sec_r)
      SEC_1: begin
        sel1 = p3s_r;
        sel2 = p1s_r;
      end
      SEC_2: begin
        sel1 = p3s_r;
        sel2 = p2s_r;
      end
      SEC_3: begin
        sel1 = p1s_r;
        sel2 = p2s_r;
      end
      SEC_4: begin
        sel1 = p1s_r;
        sel2 = p3s_r;
      end
      SEC_5: begin
        sel1 = p2s_r;
        sel2 = p3s_r;
      end
      default: begin
        sel1 = p2s_r;
        sel2 = p1s_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r    <= SINE_ROM[idx_i];
      cv_r    <= SINE_ROM[IDX_W'(DEPTH) - idx_i];
      quad1_r <= quad_i;
      s_r     <= s_nxt;
      c_r     <= c_nxt;
      dc_r    <= PRW'(volt_d_i) * PRW'(c_r);
      qs_r    <= PRW'(volt_q_i) * PRW'(s_r);
      ds_r    <= PRW'(volt_d_i) * PRW'(s_r);
      qc_r    <= PRW'(volt_q_i) * PRW'(c_r);
      ua_r    <= UW'(dc_r) - UW'(qs_r);
      ub_r    <= UW'(ds_r) + UW'(qc_r);
      a5_r    <= AW'(ua_r) * AW'(signed'({1'b0, COS30_Q16}));
      ub5_r   <= ub_r;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      p3_r    <= p3_nxt;
      p1s_r   <= p1_r;
      p2s_r   <= p2_r;
      p3s_r   <= p3_r;
      sec_r   <= sec_nxt;
      vec_r.sector <= sec_r;
      vec_r.m1     <= mag(sel1);
      vec_r.m2     <= mag(sel2);
    end
  end

  assign v_o   = v_r[7];
  assign vec_o = vec_r;

endmodule
`default_nettype wire

// ===== hdl/svpwm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, lanes share the
// divisor; a tag rides along. No dependencies.
`default_nettype none
module svpwm_div #(
  parameter int NW    = 36,
  parameter int DVW   = 16,
  parameter int QW    = 36,
  parameter int LANES = 1,
  parameter int TAGW  = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      v_i,
  input  logic [LANES-1:0][NW-1:0]  num_i,
  input  logic [DVW-1:0]            den_i,
  input  logic [TAGW-1:0]           tag_i,
  output logic                      v_o,
  output logic [LANES-1:0][QW-1:0]  quo_o,
  output logic [TAGW-1:0]           tag_o
);

  logic [LANES-1:0][DVW-1:0] rem_r   [QW];
  logic [LANES-1:0][QW-1:0]  low_r   [QW];
  logic [DVW-1:0]            den_r   [QW];
  logic [TAGW-1:0]           tag_r   [QW];
  logic                      v_r     [QW];

  logic [LANES-1:0][DVW-1:0] rem_src [QW];
  logic [LANES-1:0][QW-1:0]  low_src [QW];
  logic [DVW-1:0]            den_src [QW];
  logic [TAGW-1:0]           tag_src [QW];
  logic                      v_src   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [LANES-1:0][DVW-1:0] rem_nxt;
    logic [LANES-1:0][QW-1:0]  low_nxt;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_src[0][l] = DVW'(num_i[l] >> QW);
        assign low_src[0][l] = num_i[l][QW-1:0];
      end
      assign den_src[0] = den_i;
      assign tag_src[0] = tag_i;
      assign v_src[0]   = v_i;
    end else begin : g_next
      assign rem_src[k] = rem_r[k-1];
      assign low_src[k] = low_r[k-1];
      assign den_src[k] = den_r[k-1];
      assign tag_src[k] = tag_r[k-1];
      assign v_src[k]   = v_r[k-1];
    end

    always_comb begin
      logic [DVW:0] cand;
      logic         ge;
      for (int l = 0; l < LANES; l++) begin
        cand = {rem_src[k][l], low_src[k][l][QW-1]};
        ge   = cand >= {1'b0, den_src[k]};
        rem_nxt[l] = ge ? DVW'(cand - {1'b0, den_src[k]}) : cand[DVW-1:0];
        low_nxt[l] = {low_src[k][l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_src[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= low_nxt;
        den_r[k] <= den_src[k];
        tag_r[k] <= tag_src[k];
      end
    end
  end

  assign v_o   = v_r[QW-1];
  assign quo_o = low_r[QW-1];
  assign tag_o = tag_r[QW-1];

endmodule
`default_nettype wire
